// File: src/w3bs_pkg.sv
// Shared types, constants and register codes of the 3x3 blur and sharpen window filter.
package w3bs_pkg;

  // Largest frame the line buffers hold.
  localparam int unsigned MAX_WIDTH  = 2048;
  localparam int unsigned MAX_HEIGHT = 4096;

  // Register field widths and the configuration port.
  localparam int unsigned FW_W       = 12;
  localparam int unsigned FH_W       = 13;
  localparam int unsigned CFG_W      = 13;
  localparam int unsigned CFG_ADDR_W = 2;

  // Internal counter widths follow from the frame limits.
  localparam int unsigned COL_W     = $clog2(MAX_WIDTH);
  localparam int unsigned ACT_W_W   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned ACT_H_W   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned IN_ROW_W  = $clog2(MAX_HEIGHT + 2);
  localparam int unsigned OUT_ROW_W = $clog2(MAX_HEIGHT);
  localparam int unsigned LEAD_W    = $clog2(MAX_WIDTH + 2);

  // Register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_FILTER_MODE  = 2'd2;

  // Register reset values.
  localparam logic [FW_W-1:0] RST_FRAME_WIDTH  = 12'd640;
  localparam logic [FH_W-1:0] RST_FRAME_HEIGHT = 13'd480;
  localparam logic            RST_FILTER_MODE  = 1'b0;

  // Item and mode codes.
  localparam logic OP_PIXEL     = 1'b0;
  localparam logic OP_DRAIN     = 1'b1;
  localparam logic MODE_BLUR    = 1'b0;
  localparam logic MODE_SHARPEN = 1'b1;

  // Sums of nine 8-bit values, and the reciprocal of 9 used to divide them.
  localparam int unsigned SUM_W      = 12;
  localparam int unsigned DIV9_RECIP = 3641;
  localparam int unsigned DIV9_SHIFT = 15;

  // Queue depths.
  localparam int unsigned CQ_DEPTH = 4;
  localparam int unsigned CQ_PTR_W = $clog2(CQ_DEPTH);
  localparam int unsigned OQ_DEPTH = 2;
  localparam int unsigned OQ_PTR_W = $clog2(OQ_DEPTH);

  // One RGB pixel: index 2 is red, 1 green, 0 blue.
  typedef logic [2:0][7:0] pix_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_end;
  } out_item_t;

  // Classified work item passed from the front end to the datapath.
  typedef struct packed {
    logic             flush;
    pix_t             px;
    logic [COL_W-1:0] col;
    logic             emit;
    logic             interior;
    logic             last;
    logic             mode;
  } cmd_t;

endpackage

// File: src/w3bs_front.sv
// Front end: configuration registers, frame counters and classification of input items.
module w3bs_front
  import w3bs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  in_item_t              item_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  output logic                  cmd_push_o,
  output cmd_t                  cmd_o
);

  logic [FW_W-1:0]      frame_width_q;
  logic [FH_W-1:0]      frame_height_q;
  logic                 filter_mode_q;
  logic [ACT_W_W-1:0]   act_w_q;
  logic [ACT_H_W-1:0]   act_h_q;
  logic                 act_mode_q;
  logic [COL_W-1:0]     in_col_q;
  logic [IN_ROW_W-1:0]  in_row_q;
  logic [COL_W-1:0]     out_col_q;
  logic [OUT_ROW_W-1:0] out_row_q;
  logic [LEAD_W-1:0]    lead_q;

  logic               idle;
  logic [ACT_W_W-1:0] width_clamped;
  logic [ACT_H_W-1:0] height_clamped;
  logic [ACT_W_W-1:0] w_cur;
  logic [ACT_H_W-1:0] h_cur;
  logic               mode_cur;
  logic               flushing;
  logic               drain;
  logic               process;
  logic               emit;
  logic               interior;
  logic               last;
  logic               in_wrap;
  logic               out_wrap;

  always_comb begin
    if (frame_width_q == '0) begin
      width_clamped = ACT_W_W'(1);
    end else if (32'(frame_width_q) > MAX_WIDTH) begin
      width_clamped = ACT_W_W'(MAX_WIDTH);
    end else begin
      width_clamped = ACT_W_W'(frame_width_q);
    end
    if (frame_height_q == '0) begin
      height_clamped = ACT_H_W'(1);
    end else if (32'(frame_height_q) > MAX_HEIGHT) begin
      height_clamped = ACT_H_W'(MAX_HEIGHT);
    end else begin
      height_clamped = ACT_H_W'(frame_height_q);
    end
  end

  // The frame geometry is taken from the registers on the first pixel of a frame.
  assign idle     = (in_row_q == '0) && (in_col_q == '0);
  assign w_cur    = idle ? width_clamped : act_w_q;
  assign h_cur    = idle ? height_clamped : act_h_q;
  assign mode_cur = idle ? filter_mode_q : act_mode_q;

  assign flushing = 32'(in_row_q) >= 32'(h_cur);
  assign drain    = (item_i.operation == OP_DRAIN);
  // Drains before the flush phase, including drains while idle, are dropped.
  assign process  = accept_i && !(drain && !flushing);

  assign emit     = 32'(lead_q) == 32'(w_cur) + 32'd1;
  assign in_wrap  = 32'(in_col_q) + 32'd1 >= 32'(w_cur);
  assign out_wrap = 32'(out_col_q) + 32'd1 >= 32'(w_cur);
  assign interior = (out_row_q != '0) && (32'(out_row_q) + 32'd2 <= 32'(h_cur)) &&
                    (out_col_q != '0) && (32'(out_col_q) + 32'd2 <= 32'(w_cur));
  assign last     = (32'(out_row_q) + 32'd1 == 32'(h_cur)) &&
                    (32'(out_col_q) + 32'd1 == 32'(w_cur));

  always_comb begin
    cmd_o.flush    = flushing;
    cmd_o.px       = flushing ? pix_t'('0) : {item_i.in_red, item_i.in_green, item_i.in_blue};
    cmd_o.col      = in_col_q;
    cmd_o.emit     = emit;
    cmd_o.interior = interior;
    cmd_o.last     = last;
    cmd_o.mode     = mode_cur;
  end

  assign cmd_push_o = process;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= RST_FRAME_WIDTH;
      frame_height_q <= RST_FRAME_HEIGHT;
      filter_mode_q  <= RST_FILTER_MODE;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata_i[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i[FH_W-1:0];
        REG_FILTER_MODE:  filter_mode_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_w_q    <= ACT_W_W'(RST_FRAME_WIDTH);
      act_h_q    <= ACT_H_W'(RST_FRAME_HEIGHT);
      act_mode_q <= RST_FILTER_MODE;
      in_col_q   <= '0;
      in_row_q   <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      lead_q     <= '0;
    end else if (process) begin
      if (idle) begin
        act_w_q    <= width_clamped;
        act_h_q    <= height_clamped;
        act_mode_q <= filter_mode_q;
      end
      if (emit && last) begin
        in_col_q  <= '0;
        in_row_q  <= '0;
        out_col_q <= '0;
        out_row_q <= '0;
        lead_q    <= '0;
      end else begin
        if (!emit) begin
          lead_q <= lead_q + LEAD_W'(1);
        end
        if (in_wrap) begin
          in_col_q <= '0;
          in_row_q <= in_row_q + IN_ROW_W'(1);
        end else begin
          in_col_q <= in_col_q + COL_W'(1);
        end
        if (emit) begin
          if (out_wrap) begin
            out_col_q <= '0;
            out_row_q <= out_row_q + OUT_ROW_W'(1);
          end else begin
            out_col_q <= out_col_q + COL_W'(1);
          end
        end
      end
    end
  end

endmodule

// File: src/w3bs_cmd_queue.sv
// Short queue of classified items between the front end and the datapath.
module w3bs_cmd_queue
  import w3bs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t                slot_q [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr_q;
  logic [CQ_PTR_W-1:0] rd_ptr_q;
  logic [CQ_PTR_W:0]   count_q;
  logic                do_push;
  logic                do_pop;

  assign full_o  = 32'(count_q) == CQ_DEPTH;
  assign valid_o = count_q != '0;
  assign cmd_o   = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + CQ_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + CQ_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (CQ_PTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (CQ_PTR_W + 1)'(1);
      end
    end
  end

endmodule

// File: src/w3bs_back.sv
// Datapath: line buffers, 3x3 window, blur and sharpen arithmetic and the result queue.
module w3bs_back
  import w3bs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  input  cmd_t      head_i,
  output logic      head_pop_o,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  // Line buffers.
  pix_t line_above_mem  [MAX_WIDTH];
  pix_t line_middle_mem [MAX_WIDTH];

  // Read stage.
  logic s2_v_q;
  cmd_t s2_cmd_q;
  pix_t top_raw_q;
  pix_t mid_raw_q;
  logic byp_q;
  pix_t byp_top_q;
  pix_t byp_mid_q;
  pix_t top_eff;
  pix_t mid_eff;

  // Window stage.
  pix_t win_q [3][3];
  logic s3_v_q;
  logic s3_interior_q;
  logic s3_last_q;
  logic s3_mode_q;

  // Arithmetic stage.
  logic                    s4_v_q;
  logic [SUM_W-1:0]        s4_sum_q   [3];
  logic signed [SUM_W-1:0] s4_sharp_q [3];
  pix_t                    s4_ctr_q;
  logic                    s4_interior_q;
  logic                    s4_last_q;
  logic                    s4_mode_q;

  // Result queue.
  out_item_t           oq_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] oq_wr_q;
  logic [OQ_PTR_W-1:0] oq_rd_q;
  logic [OQ_PTR_W:0]   oq_count_q;
  logic                oq_full;
  logic                oq_push;
  logic                oq_pop;

  logic s2_rdy, s2_adv, s3_rdy, s3_adv, s4_rdy;
  logic mem_wr;

  logic [SUM_W-1:0]        sum9  [3];
  logic signed [SUM_W-1:0] sharp [3];
  logic [SUM_W-1:0]        pos5  [3];
  logic [SUM_W-1:0]        neg4  [3];
  logic [2*SUM_W-1:0]      prod  [3];
  pix_t                    res;
  out_item_t               res_item;

  assign oq_full    = 32'(oq_count_q) == OQ_DEPTH;
  assign s4_rdy     = !s4_v_q || !oq_full;
  assign oq_push    = s4_v_q && !oq_full;
  assign s3_rdy     = !s3_v_q || s4_rdy;
  assign s3_adv     = s3_v_q && s4_rdy;
  assign s2_rdy     = !s2_v_q || s3_rdy;
  assign s2_adv     = s2_v_q && s3_rdy;
  assign head_pop_o = head_valid_i && s2_rdy;

  // Flush items read the buffers but leave them untouched.
  assign mem_wr  = s2_adv && !s2_cmd_q.flush;
  assign top_eff = byp_q ? byp_top_q : top_raw_q;
  assign mid_eff = byp_q ? byp_mid_q : mid_raw_q;

  // A read at the column being written in the same cycle takes the new data.
  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      line_above_mem[s2_cmd_q.col]  <= mid_eff;
      line_middle_mem[s2_cmd_q.col] <= s2_cmd_q.px;
    end
    if (head_pop_o) begin
      top_raw_q <= line_above_mem[head_i.col];
      mid_raw_q <= line_middle_mem[head_i.col];
      byp_q     <= mem_wr && (head_i.col == s2_cmd_q.col);
      byp_top_q <= mid_eff;
      byp_mid_q <= s2_cmd_q.px;
      s2_cmd_q  <= head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q        <= 1'b0;
      s3_v_q        <= 1'b0;
      s4_v_q        <= 1'b0;
      win_q         <= '{default: '0};
      s3_interior_q <= 1'b0;
      s3_last_q     <= 1'b0;
      s3_mode_q     <= MODE_BLUR;
    end else begin
      if (s2_rdy) begin
        s2_v_q <= head_valid_i;
      end
      if (s3_rdy) begin
        s3_v_q <= s2_adv && s2_cmd_q.emit;
      end
      if (s4_rdy) begin
        s4_v_q <= s3_adv;
      end
      if (s2_adv) begin
        for (int r = 0; r < 3; r++) begin
          win_q[r][0] <= win_q[r][1];
          win_q[r][1] <= win_q[r][2];
        end
        win_q[0][2]   <= top_eff;
        win_q[1][2]   <= mid_eff;
        win_q[2][2]   <= s2_cmd_q.px;
        s3_interior_q <= s2_cmd_q.interior;
        s3_last_q     <= s2_cmd_q.last;
        s3_mode_q     <= s2_cmd_q.mode;
      end
    end
  end

  // Window sums per channel: nine-cell sum for the blur, cross kernel for the sharpen.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum9[c] = SUM_W'(win_q[0][0][c]) + SUM_W'(win_q[0][1][c]) + SUM_W'(win_q[0][2][c])
              + SUM_W'(win_q[1][0][c]) + SUM_W'(win_q[1][1][c]) + SUM_W'(win_q[1][2][c])
              + SUM_W'(win_q[2][0][c]) + SUM_W'(win_q[2][1][c]) + SUM_W'(win_q[2][2][c]);
      pos5[c]  = (SUM_W'(win_q[1][1][c]) << 2) + SUM_W'(win_q[1][1][c]);
      neg4[c]  = SUM_W'(win_q[0][1][c]) + SUM_W'(win_q[2][1][c])
               + SUM_W'(win_q[1][0][c]) + SUM_W'(win_q[1][2][c]);
      sharp[c] = $signed(pos5[c] - neg4[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_adv) begin
      s4_sum_q      <= sum9;
      s4_sharp_q    <= sharp;
      s4_ctr_q      <= win_q[1][1];
      s4_interior_q <= s3_interior_q;
      s4_last_q     <= s3_last_q;
      s4_mode_q     <= s3_mode_q;
    end
  end

  // Division by 9 through the reciprocal is exact for sums up to 9 * 255.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c] = s4_sum_q[c] * SUM_W'(DIV9_RECIP);
      if (!s4_interior_q) begin
        res[c] = s4_ctr_q[c];
      end else if (s4_mode_q == MODE_BLUR) begin
        res[c] = prod[c][DIV9_SHIFT +: 8];
      end else if (s4_sharp_q[c][SUM_W-1]) begin
        res[c] = 8'd0;
      end else if (|s4_sharp_q[c][SUM_W-2:8]) begin
        res[c] = 8'd255;
      end else begin
        res[c] = s4_sharp_q[c][7:0];
      end
    end
    res_item.out_red   = res[2];
    res_item.out_green = res[1];
    res_item.out_blue  = res[0];
    res_item.frame_end = s4_last_q;
  end

  assign empty      = oq_count_q == '0;
  assign oq_pop     = pop && !empty;
  assign out_item_o = oq_q[oq_rd_q];

  always_ff @(posedge clk_i) begin
    if (oq_push) begin
      oq_q[oq_wr_q] <= res_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q    <= '0;
      oq_rd_q    <= '0;
      oq_count_q <= '0;
    end else begin
      if (oq_push) begin
        oq_wr_q <= oq_wr_q + OQ_PTR_W'(1);
      end
      if (oq_pop) begin
        oq_rd_q <= oq_rd_q + OQ_PTR_W'(1);
      end
      if (oq_push && !oq_pop) begin
        oq_count_q <= oq_count_q + (OQ_PTR_W + 1)'(1);
      end else if (oq_pop && !oq_push) begin
        oq_count_q <= oq_count_q - (OQ_PTR_W + 1)'(1);
      end
    end
  end

endmodule

// File: src/window_3x3_blur_sharpen_unit.sv
// Top level of the 3x3 box blur and Laplacian sharpen filter for RGB raster streams.
//
// The unit filters an RGB pixel stream in raster order with a 3x3 window, each channel on
// its own: in blur mode a result is the truncated mean of the nine window pixels, in
// sharpen mode it is five times the center minus its four direct neighbors, clamped to
// 0..255. Pixels in the first and last row and column pass through unchanged, so frames
// narrower or shorter than 3 pixels come out as they went in. Width, height and mode are
// written through the configuration port and are sampled when the first pixel of a frame
// is transferred; a width or height of zero counts as one and values above 2048 columns
// or 4096 rows saturate. Results lag the input by width+1 transfers, so after the last
// pixel the source transfers width+1 drain items to flush the frame; drains at any other
// time are discarded, and a pixel transferred during the flush counts as a drain. The
// last result of a frame carries frame_end. The unit takes one item per clock cycle
// sustained while full is low, limited by the single read and write port of each line
// buffer; results pass through the read, window and arithmetic stages. Input and output
// both look like a queue: the input side takes a transfer while full is low, and results
// wait in a two-entry queue so a stalled consumer does not stop the input at once. Inside,
// a front end classifies items and keeps the frame counters, a four-entry queue decouples
// it from the datapath that reads and writes the line buffers, shifts the window and
// computes the kernels. The line buffers start with undefined content and need no
// clearing after reset.
module window_3x3_blur_sharpen_unit
  import w3bs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input item queue side.
  input  logic                  push,
  output logic                  full,
  input  in_item_t              in_item_i,
  // Result queue side.
  output logic                  empty,
  input  logic                  pop,
  output out_item_t             out_item_o,
  // Configuration writes.
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i
);

  logic accept;
  logic cmd_push;
  cmd_t cmd_in;
  logic cmd_valid;
  cmd_t cmd_head;
  logic cmd_pop;

  // A transfer is taken whenever the command queue has room; dropped drains use a slot
  // of that decision but never enter the queue.
  assign accept = push && !full;

  w3bs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in)
  );

  w3bs_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .cmd_o   (cmd_head)
  );

  w3bs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (cmd_valid),
    .head_i       (cmd_head),
    .head_pop_o   (cmd_pop),
    .empty        (empty),
    .pop          (pop),
    .out_item_o   (out_item_o)
  );

endmodule

// File: verif/window_3x3_blur_sharpen_unit_checker.sv
// Checker for the 3x3 blur and sharpen unit: predicts every filtered pixel and compares results.
module window_3x3_blur_sharpen_unit_checker
  import w3bs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic                  full_i,
  input  in_item_t              in_item_i,
  input  logic                  empty_i,
  input  logic                  pop_i,
  input  out_item_t             out_item_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  output int                    mismatches_o,
  output int                    results_pending_o,
  output logic                  frame_open_o,
  output logic                  flushing_o
);

  logic [FW_W-1:0] reg_width  = RST_FRAME_WIDTH;
  logic [FH_W-1:0] reg_height = RST_FRAME_HEIGHT;
  logic            reg_mode   = RST_FILTER_MODE;

  int unsigned frame_w    = 32'(RST_FRAME_WIDTH);
  int unsigned frame_h    = 32'(RST_FRAME_HEIGHT);
  logic        frame_mode = RST_FILTER_MODE;

  pix_t        above_line  [MAX_WIDTH];
  pix_t        middle_line [MAX_WIDTH];
  pix_t        window_px   [9];
  int unsigned in_col  = 0;
  int unsigned in_row  = 0;
  int unsigned out_col = 0;
  int unsigned out_row = 0;

  out_item_t pixels_due[$];
  int        due_count = 0;
  int        mistakes  = 0;

  assign mismatches_o      = mistakes;
  assign results_pending_o = due_count;
  assign frame_open_o      = (in_row != 0) || (in_col != 0);
  assign flushing_o        = frame_open_o && (in_row >= frame_h);

  function automatic int unsigned size_in_use(int unsigned v, int unsigned top);
    if (v == 0) return 1;
    return (v > top) ? top : v;
  endfunction

  // One channel of the kernel; channel 2 is red, 1 green and 0 blue.
  function automatic logic [7:0] kernel_result(int ch);
    int acc;
    acc = 0;
    if (frame_mode == MODE_BLUR) begin
      for (int i = 0; i < 9; i++) acc += int'(window_px[i][ch]);
      return 8'(acc / 9);
    end
    acc = 5 * int'(window_px[4][ch]) - int'(window_px[1][ch]) - int'(window_px[3][ch])
          - int'(window_px[5][ch]) - int'(window_px[7][ch]);
    if (acc < 0) acc = 0;
    else if (acc > 255) acc = 255;
    return 8'(acc);
  endfunction

  // Advances the window by one accepted item and queues the pixel it releases, if any.
  task automatic take_item(in_item_t it);
    pix_t        px;
    pix_t        top_px;
    pix_t        mid_px;
    int unsigned col;
    bit          flush_item;
    bit          emit;
    bit          interior;
    bit          last;
    out_item_t   res;
    if (in_row == 0 && in_col == 0) begin
      if (it.operation == OP_DRAIN) return;
      frame_w    = size_in_use(32'(reg_width), MAX_WIDTH);
      frame_h    = size_in_use(32'(reg_height), MAX_HEIGHT);
      frame_mode = reg_mode;
    end
    flush_item = in_row >= frame_h;
    if (!flush_item && it.operation == OP_DRAIN) return;
    px     = flush_item ? pix_t'('0) : pix_t'({it.in_red, it.in_green, it.in_blue});
    col    = (in_col < MAX_WIDTH) ? in_col : MAX_WIDTH - 1;
    top_px = above_line[col];
    mid_px = middle_line[col];
    if (!flush_item) begin
      above_line[col]  = mid_px;
      middle_line[col] = px;
    end
    for (int r = 0; r < 3; r++) begin
      window_px[3*r]   = window_px[3*r+1];
      window_px[3*r+1] = window_px[3*r+2];
    end
    window_px[2] = top_px;
    window_px[5] = mid_px;
    window_px[8] = px;

    emit = in_row * frame_w + in_col >= frame_w + 1;
    in_col++;
    if (in_col >= frame_w) begin
      in_col = 0;
      in_row++;
    end
    if (!emit) return;

    interior = out_row >= 1 && out_row + 2 <= frame_h && out_col >= 1 && out_col + 2 <= frame_w;
    if (interior) begin
      res.out_red   = kernel_result(2);
      res.out_green = kernel_result(1);
      res.out_blue  = kernel_result(0);
    end else begin
      res.out_red   = window_px[4][2];
      res.out_green = window_px[4][1];
      res.out_blue  = window_px[4][0];
    end
    last          = (out_row + 1 == frame_h) && (out_col + 1 == frame_w);
    res.frame_end = last;
    pixels_due.push_back(res);

    if (last) begin
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
    end else begin
      out_col++;
      if (out_col >= frame_w) begin
        out_col = 0;
        out_row++;
      end
    end
  endtask

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mistakes++;
    end
  endfunction

  task automatic compare_result(out_item_t got);
    out_item_t want;
    if (pixels_due.size() == 0) begin
      $display("%0t: result with nothing predicted, expected none actual %h", $time, got);
      mistakes++;
      return;
    end
    want = pixels_due.pop_front();
    check_field("out_red", want.out_red, got.out_red);
    check_field("out_green", want.out_green, got.out_green);
    check_field("out_blue", want.out_blue, got.out_blue);
    check_field("frame_end", 8'(want.frame_end), 8'(got.frame_end));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_width  = RST_FRAME_WIDTH;
      reg_height = RST_FRAME_HEIGHT;
      reg_mode   = RST_FILTER_MODE;
      frame_w    = 32'(RST_FRAME_WIDTH);
      frame_h    = 32'(RST_FRAME_HEIGHT);
      frame_mode = RST_FILTER_MODE;
      for (int i = 0; i < 9; i++) window_px[i] = '0;
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
      pixels_due.delete();
    end else begin
      if (push_i && !full_i) take_item(in_item_i);
      if (pop_i && !empty_i) compare_result(out_item_i);
      // A register write at the same edge as a transfer counts from the next item on.
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_FRAME_WIDTH:  reg_width  = cfg_wdata_i[FW_W-1:0];
          REG_FRAME_HEIGHT: reg_height = cfg_wdata_i[FH_W-1:0];
          REG_FILTER_MODE:  reg_mode   = cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
    due_count = pixels_due.size();
  end

endmodule

// File: verif/window_3x3_blur_sharpen_unit_tb.sv
// Testbench top of the 3x3 blur and sharpen unit: stimulus, idling and the final verdict.
module window_3x3_blur_sharpen_unit_tb;
  import w3bs_pkg::*;

  // The cap on the run is taken from the slowest legal run (every item behind a full
  // sender gap and every result behind a full consumer stall) and then several times over.
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  // This covers the path from a transfer through the block's registered stages to a result
  // and any drains still moving through the internal command queue.
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned RANDOM_ITEMS  = 1000;
  // From this point on neither side idles any more.
  localparam int unsigned CALM_ITEMS    = 850;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  push      = 1'b0;
  logic                  full;
  in_item_t              in_item   = '0;
  logic                  empty;
  logic                  pop       = 1'b0;
  out_item_t             out_item;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = REG_FRAME_WIDTH;
  logic [CFG_W-1:0]      cfg_wdata = '0;

  int   mismatches;
  int   results_pending;
  logic frame_open;
  logic flushing;

  int unsigned cycles     = 0;
  int unsigned items_sent = 0;
  int unsigned pop_hold   = 0;
  bit          in_gaps    = 1'b0;
  bit          out_gaps   = 1'b0;
  bit          calm       = 1'b0;
  // Effective frame size of the setup most recently written.
  int unsigned frame_w;
  int unsigned frame_h;

  window_3x3_blur_sharpen_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_addr_i  (cfg_addr),
    .cfg_wdata_i (cfg_wdata)
  );

  window_3x3_blur_sharpen_unit_checker checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push_i            (push),
    .full_i            (full),
    .in_item_i         (in_item),
    .empty_i           (empty),
    .pop_i             (pop),
    .out_item_i        (out_item),
    .cfg_we_i          (cfg_we),
    .cfg_addr_i        (cfg_addr),
    .cfg_wdata_i       (cfg_wdata),
    .mismatches_o      (mismatches),
    .results_pending_o (results_pending),
    .frame_open_o      (frame_open),
    .flushing_o        (flushing)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // A hung block ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("window_3x3_blur_sharpen_unit_tb failed");
      $finish;
    end
  end

  // The consumer pops every cycle except during random stall bursts. A new pop value is
  // scheduled once per rising edge, so a transfer happens at the next edge with empty low.
  initial begin
    forever begin
      @(posedge clk_i);
      if (pop_hold != 0) begin
        pop_hold--;
        pop <= 1'b0;
      end else if (out_gaps && !calm && $urandom_range(0, 11) == 0) begin
        pop_hold = $urandom_range(1, 19) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  function automatic int unsigned active_size(int unsigned v, int unsigned top);
    if (v == 0) return 1;
    return (v > top) ? top : v;
  endfunction

  // Channel values lean toward the extremes so that blur saturation and sharpen clamping
  // both show up often.
  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_item(logic op);
    in_item_t it;
    it.operation = op;
    it.in_red    = pick_level();
    it.in_green  = pick_level();
    it.in_blue   = pick_level();
    return it;
  endfunction

  function automatic in_item_t pixel_item(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    return '{OP_PIXEL, r, g, b};
  endfunction

  // Writes all three registers on consecutive edges with the write enable held high, so
  // that the enable is scheduled only once per time step. Called only while the block is idle.
  task automatic load_frame_setup(int unsigned w, int unsigned h, logic mode);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_FRAME_WIDTH;
    cfg_wdata <= CFG_W'(w);
    @(posedge clk_i);
    cfg_addr  <= REG_FRAME_HEIGHT;
    cfg_wdata <= CFG_W'(h);
    @(posedge clk_i);
    cfg_addr  <= REG_FILTER_MODE;
    cfg_wdata <= CFG_W'(mode);
    @(posedge clk_i);
    cfg_we  <= 1'b0;
    frame_w = active_size(w, MAX_WIDTH);
    frame_h = active_size(h, MAX_HEIGHT);
  endtask

  // Presents one item and returns at the edge of its transfer with push still high, so
  // that a following item can go out back to back.
  task automatic send_item(in_item_t it);
    in_item <= it;
    push    <= 1'b1;
    do @(posedge clk_i); while (full);
    items_sent++;
  endtask

  task automatic maybe_pause();
    if (in_gaps && !calm && $urandom_range(0, 9) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  // One frame of random pixels followed by its flush. Along the way it sends a drain while
  // idle, drains before the last pixel and pixels inside the flush, all of which the block
  // must treat as drains or ignore. A broken frame gets a short flush, so the next frame's
  // first pixels finish the flush and the stream runs out of step with the frame grid.
  task automatic stream_frame(bit allow_broken);
    int unsigned flush_len;
    if ($urandom_range(0, 3) == 0) begin
      maybe_pause();
      send_item(random_item(OP_DRAIN));
    end
    for (int unsigned i = 0; i < frame_w * frame_h; i++) begin
      maybe_pause();
      if (i != 0 && $urandom_range(0, 31) == 0) send_item(random_item(OP_DRAIN));
      send_item(random_item(OP_PIXEL));
    end
    flush_len = frame_w + 1;
    if (allow_broken && $urandom_range(0, 5) == 0) flush_len = $urandom_range(0, frame_w);
    for (int unsigned j = 0; j < flush_len; j++) begin
      maybe_pause();
      send_item(random_item($urandom_range(0, 7) == 0 ? OP_PIXEL : OP_DRAIN));
    end
    if ($urandom_range(0, 4) == 0) send_item(random_item(OP_DRAIN));
  endtask

  // Closes any frame that is still open (pixels while it is filling, drains while it is
  // flushing), waits for every predicted result and then lets the pipeline empty. The
  // frame state is read at the falling edge, after the checker has seen the last transfer.
  task automatic close_and_settle();
    bit drain_next;
    forever begin
      push <= 1'b0;
      @(negedge clk_i);
      if (!frame_open) break;
      drain_next = flushing;
      @(posedge clk_i);
      send_item(random_item(drain_next ? OP_DRAIN : OP_PIXEL));
    end
    while (results_pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    // Register values of zero check that zero counts as one; the others are thin frames
    // that pass through whole. Each pairs one edge size with a small other side.
    int unsigned edge_w[5];
    int unsigned edge_h[5];
    int unsigned random_start;
    int unsigned w;
    int unsigned h;

    edge_w = '{0, 40, 1, 3, 2};
    edge_h = '{2, 0, 9, 1, 0};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: a 3x3 blur frame whose single interior pixel is the mean of eight 255s
    // and one 0 in green (truncated), all 255 in red and all 0 in blue. A drain before the
    // frame and one in its middle are ignored, and a pixel inside the flush acts as a drain.
    load_frame_setup(3, 3, MODE_BLUR);
    send_item(random_item(OP_DRAIN));
    for (int i = 0; i < 9; i++) begin
      send_item(pixel_item(8'd255, (i == 0) ? 8'd0 : 8'd255, 8'd0));
      if (i == 4) send_item(random_item(OP_DRAIN));
    end
    send_item(random_item(OP_DRAIN));
    send_item(random_item(OP_PIXEL));
    send_item(random_item(OP_DRAIN));
    send_item(random_item(OP_DRAIN));
    // An extra drain after the frame has completed gives nothing.
    send_item(random_item(OP_DRAIN));
    close_and_settle();

    // Sharpen: the center clamps high in red, low in green and lands in range, at 240, in blue.
    load_frame_setup(3, 3, MODE_SHARPEN);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) send_item(pixel_item(8'd255, 8'd0, 8'd128));
      else        send_item(pixel_item(8'd0, 8'd255, 8'd100));
    end
    repeat (4) send_item(random_item(OP_DRAIN));
    close_and_settle();

    // Edge frame sizes, with idling on both sides.
    in_gaps  = 1'b1;
    out_gaps = 1'b1;
    for (int k = 0; k < 5; k++) begin
      load_frame_setup(edge_w[k], edge_h[k], logic'(k[0]));
      stream_frame(1'b0);
      close_and_settle();
    end

    // Random part: mostly small frames in both modes, a few frames per setup, some of them
    // broken. Idling is switched per setup, so some stretches run without any.
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      calm     = (items_sent - random_start) >= CALM_ITEMS;
      in_gaps  = $urandom_range(0, 3) != 0;
      out_gaps = $urandom_range(0, 3) != 0;
      case ($urandom_range(0, 9))
        0:       w = 0;
        1:       w = $urandom_range(13, 64);
        default: w = $urandom_range(1, 12);
      endcase
      h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
      load_frame_setup(w, h, 1'($urandom));
      repeat ($urandom_range(1, 3)) stream_frame(1'b1);
      close_and_settle();
    end

    @(negedge clk_i);
    if (mismatches == 0 && results_pending == 0) begin
      $display("window_3x3_blur_sharpen_unit_tb passed");
    end else begin
      $display("window_3x3_blur_sharpen_unit_tb failed");
    end
    $finish;
  end

endmodule

// File: files.f
src/w3bs_pkg.sv
src/w3bs_front.sv
src/w3bs_cmd_queue.sv
src/w3bs_back.sv
src/window_3x3_blur_sharpen_unit.sv
verif/window_3x3_blur_sharpen_unit_checker.sv
verif/window_3x3_blur_sharpen_unit_tb.sv
